/* rtl/lmv_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lmv_pkg;

    // histogram geometry
    localparam int LABEL_RANGE = 32768;
    localparam int MAX_SAMPLES = 4096;
    localparam int AddrW       = $clog2(LABEL_RANGE);

    // field widths
    localparam int LabelW = 15;
    localparam int CountW = 13;
    localparam int FieldCountMax = (1 << CountW) - 1;
    localparam int CountCapInt   = (MAX_SAMPLES < FieldCountMax) ? MAX_SAMPLES : FieldCountMax;
    localparam logic [CountW-1:0] CountCap = CountW'(CountCapInt);

    // group epoch tag kept with every histogram entry
    localparam int EpochW = 8;
    localparam logic [EpochW-1:0] EpochMax   = '1;
    localparam logic [EpochW-1:0] EpochFirst = EpochW'(1);

    typedef struct packed {
        logic [EpochW-1:0] epoch;
        logic [CountW-1:0] count;
    } t_hist_word;

    localparam int WordW = $bits(t_hist_word);

    // histogram write request from the tally stage
    typedef struct packed {
        logic             en;
        logic [AddrW-1:0] addr;
        t_hist_word       word;
    } t_wr_req;

    // tally stage status toward the front end
    typedef struct packed {
        logic s1_valid;
        logic can_take;
    } t_tally_stat;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_RUN,
        ST_WRAP
    } t_state;

endpackage

`default_nettype wire

/* rtl/lmv_hist_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module lmv_hist_ram #(
    parameter int DEPTH = 32768,
    parameter int WIDTH = 21
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/lmv_tally.sv */
`timescale 1ns / 1ps
`default_nettype none

module lmv_tally (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_accept,
    input  wire logic [15:0]                  i_label_value,
    input  wire logic                         i_group_end,
    input  wire logic [lmv_pkg::EpochW-1:0]   i_epoch,
    input  wire logic                         i_flush,
    input  wire lmv_pkg::t_hist_word          i_rd_data,
    output lmv_pkg::t_wr_req                  o_wr,
    output lmv_pkg::t_tally_stat              o_stat,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [lmv_pkg::LabelW-1:0]        o_winning_label,
    output logic [lmv_pkg::CountW-1:0]        o_winning_count
);

    logic                          r_s1_valid;
    logic                          r_s1_end;
    logic                          r_s1_hit;
    logic [lmv_pkg::LabelW-1:0]    r_s1_label;
    logic [lmv_pkg::EpochW-1:0]    r_s1_epoch;

    logic                          r_fw_valid;
    logic [lmv_pkg::LabelW-1:0]    r_fw_label;
    lmv_pkg::t_hist_word           r_fw_word;

    logic [lmv_pkg::LabelW-1:0]    r_best_label;
    logic [lmv_pkg::CountW-1:0]    r_best_count;

    logic                          r_out_valid;
    logic [lmv_pkg::LabelW-1:0]    r_out_label;
    logic [lmv_pkg::CountW-1:0]    r_out_count;

    logic                          label_ok;
    logic                          s1_go;
    lmv_pkg::t_hist_word           cur_word;
    logic [lmv_pkg::CountW-1:0]    cnt_old;
    logic [lmv_pkg::CountW-1:0]    cnt_new;
    logic                          take;
    logic [lmv_pkg::LabelW-1:0]    n_best_label;
    logic [lmv_pkg::CountW-1:0]    n_best_count;

    // positive label inside the histogram range
    assign label_ok = !i_label_value[15] && (i_label_value != 16'd0)
                      && ({16'd0, i_label_value} < 32'(lmv_pkg::LABEL_RANGE));

    // a group end waits for room in the output register
    assign s1_go = r_s1_valid && !(r_s1_end && r_out_valid && !i_out_ready);

    assign o_stat.s1_valid = r_s1_valid;
    assign o_stat.can_take = !r_s1_valid || s1_go;

    // forward the last write over the stale read of the same entry
    assign cur_word = (r_fw_valid && (r_fw_label == r_s1_label)) ? r_fw_word : i_rd_data;

    // an entry from an older group counts as empty
    assign cnt_old = (cur_word.epoch == r_s1_epoch) ? cur_word.count : '0;
    assign cnt_new = (cnt_old < lmv_pkg::CountCap) ? cnt_old + lmv_pkg::CountW'(1) : cnt_old;

    // running best, smallest label on a tie
    assign take = r_s1_hit && ((cnt_new > r_best_count)
                  || ((cnt_new == r_best_count) && (r_s1_label < r_best_label)));
    assign n_best_label = take ? r_s1_label : r_best_label;
    assign n_best_count = take ? cnt_new : r_best_count;

    // histogram write back
    assign o_wr.en         = s1_go && r_s1_hit;
    assign o_wr.addr       = r_s1_label[lmv_pkg::AddrW-1:0];
    assign o_wr.word.epoch = r_s1_epoch;
    assign o_wr.word.count = cnt_new;

    // tally stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_end   <= i_group_end;
            r_s1_hit   <= label_ok;
            r_s1_label <= i_label_value[lmv_pkg::LabelW-1:0];
            r_s1_epoch <= i_epoch;
        end
    end

    // forwarding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_flush) begin
            r_fw_valid <= 1'b0;
        end else if (o_wr.en) begin
            r_fw_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_wr.en) begin
            r_fw_label <= r_s1_label;
            r_fw_word  <= o_wr.word;
        end
    end

    // best so far, cleared at the end of each group
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_label <= '0;
            r_best_count <= '0;
        end else if (s1_go) begin
            if (r_s1_end) begin
                r_best_label <= '0;
                r_best_count <= '0;
            end else begin
                r_best_label <= n_best_label;
                r_best_count <= n_best_count;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_s1_end) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_end) begin
            r_out_label <= n_best_label;
            r_out_count <= n_best_count;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_winning_label = r_out_label;
    assign o_winning_count = r_out_count;

endmodule

`default_nettype wire

/* rtl/label_majority_vote.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel | handshake                   | payload
// --------+-----------------------------+----------------------------------
// sample  | i_in_valid / o_in_ready     | i_label_value[15:0] s, i_group_end
// result  | o_out_valid / i_out_ready   | o_winning_label[14:0], o_winning_count[12:0]
//
// one sample per cycle while o_in_ready is high; the histogram read is registered,
// the tally stage writes the entry back, and a forwarding register covers equal
// labels on consecutive samples. the result is registered: the group's last
// sample passes the tally stage register and then the output register.
// after reset the histogram memory is swept, one entry a cycle, over all 32768
// entries with o_in_ready low. the same sweep runs after every 255th group, when the
// 8-bit group tag stored with each entry wraps.
// a pending result that is not taken stalls the next group end, and with it
// the sample input.

module label_majority_vote (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [15:0]                 i_label_value,
    input  wire logic                        i_group_end,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [lmv_pkg::LabelW-1:0]       o_winning_label,
    output logic [lmv_pkg::CountW-1:0]       o_winning_count
);

    lmv_pkg::t_state               r_state;
    lmv_pkg::t_state               n_state;
    logic [lmv_pkg::AddrW-1:0]     r_clr_addr;
    logic [lmv_pkg::AddrW-1:0]     n_clr_addr;
    logic [lmv_pkg::EpochW-1:0]    r_epoch;
    logic [lmv_pkg::EpochW-1:0]    n_epoch;

    logic                          accept;
    logic                          clearing;
    lmv_pkg::t_wr_req              tally_wr;
    lmv_pkg::t_tally_stat          tally_stat;
    lmv_pkg::t_hist_word           rd_word;
    logic [lmv_pkg::WordW-1:0]     rd_bits;
    logic                          ram_wr_en;
    logic [lmv_pkg::AddrW-1:0]     ram_wr_addr;
    logic [lmv_pkg::WordW-1:0]     ram_wr_data;

    assign clearing   = (r_state == lmv_pkg::ST_CLEAR);
    assign o_in_ready = (r_state == lmv_pkg::ST_RUN) && tally_stat.can_take;
    assign accept     = i_in_valid && o_in_ready;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= lmv_pkg::ST_CLEAR;
            r_clr_addr <= '0;
            r_epoch    <= lmv_pkg::EpochFirst;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_epoch    <= n_epoch;
        end
    end

    // clearing sweep, group tag advance and wrap
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_epoch    = r_epoch;
        unique case (r_state)
            lmv_pkg::ST_CLEAR: begin
                n_clr_addr = r_clr_addr + lmv_pkg::AddrW'(1);
                if (r_clr_addr == lmv_pkg::AddrW'(lmv_pkg::LABEL_RANGE - 1)) begin
                    n_state    = lmv_pkg::ST_RUN;
                    n_clr_addr = '0;
                    n_epoch    = lmv_pkg::EpochFirst;
                end
            end
            lmv_pkg::ST_RUN: begin
                if (accept && i_group_end) begin
                    if (r_epoch == lmv_pkg::EpochMax) begin
                        n_state = lmv_pkg::ST_WRAP;
                    end else begin
                        n_epoch = r_epoch + lmv_pkg::EpochW'(1);
                    end
                end
            end
            lmv_pkg::ST_WRAP: begin
                if (!tally_stat.s1_valid) begin
                    n_state = lmv_pkg::ST_CLEAR;
                end
            end
            default: begin
                n_state = lmv_pkg::ST_CLEAR;
            end
        endcase
    end

    // write port shared by the sweep and the tally stage
    assign ram_wr_en   = clearing || tally_wr.en;
    assign ram_wr_addr = clearing ? r_clr_addr : tally_wr.addr;
    assign ram_wr_data = clearing ? '0 : tally_wr.word;
    assign rd_word     = rd_bits;

    lmv_hist_ram #(
        .DEPTH (lmv_pkg::LABEL_RANGE),
        .WIDTH (lmv_pkg::WordW)
    ) u_hist_ram (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (i_label_value[lmv_pkg::AddrW-1:0]),
        .o_rd_data (rd_bits),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data)
    );

    lmv_tally u_tally (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_label_value   (i_label_value),
        .i_group_end     (i_group_end),
        .i_epoch         (r_epoch),
        .i_flush         (clearing),
        .i_rd_data       (rd_word),
        .o_wr            (tally_wr),
        .o_stat          (tally_stat),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_winning_label (o_winning_label),
        .o_winning_count (o_winning_count)
    );

endmodule

`default_nettype wire

/* rtl/lmv_chk.sv */
`timescale 1ns / 1ps
`default_nettype none

module lmv_chk (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        o_in_ready,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_ready,
    input wire logic [lmv_pkg::LabelW-1:0]  o_winning_label,
    input wire logic [lmv_pkg::CountW-1:0]  o_winning_count
);

    // a result waiting for transfer holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_winning_label)
        && $stable(o_winning_count))
        else $error("result changed before transfer");

    // an empty group gives label 0 with count 0, a counted label never count 0
    a_empty_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_winning_label == '0) == (o_winning_count == '0)))
        else $error("label and count disagree on an empty group");

    // counts saturate at the sample limit
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_winning_count <= lmv_pkg::CountCap))
        else $error("count above the sample limit");

    // the histogram sweep after reset keeps samples out
    a_sweep_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_in_ready)
        else $error("sample input ready during the reset sweep");

endmodule

bind label_majority_vote lmv_chk u_lmv_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_winning_label (o_winning_label),
    .o_winning_count (o_winning_count)
);

`default_nettype wire
